@@ hw/rtl/drf_pkg.sv @@
// Shared constants and types for the duplicate request filter.
package drf_pkg;

  localparam int CACHE_ENTRIES_DEF = 128;
  localparam int ID_W   = 32;
  localparam int TIME_W = 32;
  localparam int HOP_W  = 16;
  localparam int SLOT_W = 7;

  // Per-cycle controls from the sequencer to the scan unit
  typedef struct packed {
    logic clear;  // restart accumulation for a new request
    logic en;     // an entry read is valid this cycle
  } scan_ctrl_t;

endpackage

@@ hw/rtl/duplicate_request_filter_top.sv @@
// Top level of the duplicate request filter: sequencer, cache store and scan unit.
//
// Usage: drive req_id, hop_count, now_seconds and well_formed and raise
// start; the request is taken at a clock edge where start is high and busy
// is low. The block then scans every cache entry, one per cycle, through a
// single compare unit fed by the cache memory read port, and writes the new
// entry if the request is new. After the scan, the decide state registers
// answer, relay, relay_hops, slot and evicted, and done is high for exactly
// one cycle with them. busy is low again in the cycle done is high, so the
// block takes no new request until it is through with the last one. The
// memory read port, one entry per cycle, sets the request rate.
// Reset (rst, synchronous) starts a clearing pass that writes every entry
// to zero; busy is high during it.
// Results are presented for one cycle only; the receiver cannot stall.
module duplicate_request_filter_top #(
  parameter int CACHE_ENTRIES = drf_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [drf_pkg::ID_W-1:0]          req_id,
  input  logic signed [drf_pkg::HOP_W-1:0]  hop_count,
  input  logic [drf_pkg::TIME_W-1:0]        now_seconds,
  input  logic                              well_formed,
  output logic                              done,
  output logic                              answer,
  output logic                              relay,
  output logic signed [drf_pkg::HOP_W-1:0]  relay_hops,
  output logic [drf_pkg::SLOT_W-1:0]        slot,
  output logic                              evicted
);
  import drf_pkg::*;

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [IDX_W-1:0]        addr_cnt;
  logic                    rd_valid;
  logic [IDX_W-1:0]        rd_idx;
  logic [ID_W-1:0]         key;
  logic signed [HOP_W-1:0] hops;
  logic [TIME_W-1:0]       now;
  logic                    ok;

  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [ID_W+TIME_W-1:0]   mem_wdata;
  logic [ID_W+TIME_W-1:0]   mem_rdata;

  scan_ctrl_t       scan_ctrl;
  logic             match;
  logic             have_empty;
  logic [IDX_W-1:0] empty_idx;
  logic [IDX_W-1:0] oldest_idx;

  logic                      accept;
  logic                      is_new;
  logic [IDX_W-1:0]          pick_idx;
  logic [SLOT_W+IDX_W-1:0]   pick_ext;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Sequence: clear pass, wait, scan, decide and write
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (addr_cnt == LAST_IDX) state_next = S_IDLE;
      S_IDLE:   if (start) state_next = S_SCAN;
      S_SCAN:   if (rd_valid && rd_idx == LAST_IDX) state_next = S_DECIDE;
      S_DECIDE: state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // Advance the state and the shared address counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      addr_cnt <= '0;
      rd_valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_valid <= (state == S_SCAN) && !(rd_valid && rd_idx == LAST_IDX)
                  && !(rd_idx == LAST_IDX && rd_valid == 1'b0 && addr_cnt == '0
                       && state != S_SCAN);
      if (state == S_CLEAR || state == S_SCAN) begin
        addr_cnt <= (addr_cnt == LAST_IDX) ? '0 : addr_cnt + 1'b1;
      end else begin
        addr_cnt <= '0;
      end
    end
  end

  // Track which entry the registered read data belongs to
  always_ff @(posedge clk) begin
    rd_idx <= addr_cnt;
  end

  // Hold the request fields for the whole scan
  always_ff @(posedge clk) begin
    if (accept) begin
      key  <= req_id;
      hops <= hop_count;
      now  <= now_seconds;
      ok   <= well_formed;
    end
  end

  // Clear on accept, fold read data only when valid; last read issues as counter wraps
  assign scan_ctrl.clear = accept;
  assign scan_ctrl.en    = rd_valid;

  // Pick the target slot: first empty, else the oldest entry
  assign is_new    = ok && !match;
  assign pick_idx  = have_empty ? empty_idx : oldest_idx;
  assign pick_ext  = {{SLOT_W{1'b0}}, pick_idx};

  // Write zero during the clear pass, the new entry at decide time
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_cnt;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_DECIDE && is_new) begin
      mem_we    = 1'b1;
      mem_waddr = pick_idx;
      mem_wdata = {key, now};
    end
  end

  // Register the result and strobe it for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_DECIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      answer     <= is_new;
      relay      <= is_new && (hops > 16'sd1);
      relay_hops <= (is_new && (hops > 16'sd1)) ? hops - 16'sd1 : '0;
      slot       <= is_new ? pick_ext[SLOT_W-1:0] : '0;
      evicted    <= is_new && !have_empty;
    end
  end

  drf_cache_mem #(
    .CACHE_ENTRIES(CACHE_ENTRIES),
    .IDX_W(IDX_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(addr_cnt),
    .rdata(mem_rdata)
  );

  drf_scan_unit #(
    .CACHE_ENTRIES(CACHE_ENTRIES),
    .IDX_W(IDX_W)
  ) u_scan (
    .clk       (clk),
    .ctrl      (scan_ctrl),
    .key       (key),
    .idx       (rd_idx),
    .entry_id  (mem_rdata[ID_W+TIME_W-1:TIME_W]),
    .entry_time(mem_rdata[TIME_W-1:0]),
    .match     (match),
    .have_empty(have_empty),
    .empty_idx (empty_idx),
    .oldest_idx(oldest_idx)
  );

  // A result only follows a decide cycle
  a_done_after_decide: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DECIDE))
    else $error("done without a decide cycle");

  // The block is ready again while the result is shown
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while presenting a result");

  // Eviction and relay only for an answered request
  a_evict_answer: assert property (@(posedge clk) disable iff (rst)
    done && (evicted || relay) |-> answer)
    else $error("evict or relay without answer");

  // Memory writes happen only in the clear pass or at decide time
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_DECIDE))
    else $error("cache written outside clear or decide");

  // Scan reads are consumed only while scanning
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> state == S_SCAN)
    else $error("read data valid outside scan");

endmodule

@@ hw/rtl/drf_cache_mem.sv @@
// Cache store of (id, time) pairs: one write port, one registered read port.
module drf_cache_mem #(
  parameter int CACHE_ENTRIES = drf_pkg::CACHE_ENTRIES_DEF,
  parameter int IDX_W = $clog2(CACHE_ENTRIES)
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [IDX_W-1:0]                         waddr,
  input  logic [drf_pkg::ID_W+drf_pkg::TIME_W-1:0] wdata,
  input  logic [IDX_W-1:0]                         raddr,
  output logic [drf_pkg::ID_W+drf_pkg::TIME_W-1:0] rdata
);
  import drf_pkg::*;

  logic [ID_W+TIME_W-1:0] mem [CACHE_ENTRIES];

  // Write one entry, read one entry, both registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/drf_scan_unit.sv @@
// Shared compare unit: folds one cache entry per cycle into match, empty and oldest.
module drf_scan_unit #(
  parameter int CACHE_ENTRIES = drf_pkg::CACHE_ENTRIES_DEF,
  parameter int IDX_W = $clog2(CACHE_ENTRIES)
) (
  input  logic                       clk,
  input  drf_pkg::scan_ctrl_t        ctrl,
  input  logic [drf_pkg::ID_W-1:0]   key,
  input  logic [IDX_W-1:0]           idx,
  input  logic [drf_pkg::ID_W-1:0]   entry_id,
  input  logic [drf_pkg::TIME_W-1:0] entry_time,
  output logic                       match,
  output logic                       have_empty,
  output logic [IDX_W-1:0]           empty_idx,
  output logic [IDX_W-1:0]           oldest_idx
);
  import drf_pkg::*;

  logic [TIME_W-1:0] min_time;
  logic              is_match;
  logic              is_empty;
  logic              is_older;

  // Compare the entry against the key, the empty mark and the running minimum
  assign is_match = (entry_id == key);
  assign is_empty = (entry_id == '0);
  assign is_older = (idx == '0) || (entry_time < min_time);

  // Accumulate over the scan; keep the first empty and the first smallest time
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      match      <= 1'b0;
      have_empty <= 1'b0;
    end else if (ctrl.en) begin
      if (is_match) begin
        match <= 1'b1;
      end
      if (is_empty && !have_empty) begin
        have_empty <= 1'b1;
        empty_idx  <= idx;
      end
      if (is_older) begin
        min_time   <= entry_time;
        oldest_idx <= idx;
      end
    end
  end

endmodule
